// ===== rtl/dlf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dlf_pkg;

    // Sizes of the stores
    localparam int MAX_INPUTS  = 64;
    localparam int MAX_OUTPUTS = 64;
    localparam int IN_W        = $clog2(MAX_INPUTS);
    localparam int OUT_W       = $clog2(MAX_OUTPUTS);
    localparam int WADDR_W     = IN_W + OUT_W;

    // Field and datapath widths
    localparam int LEN_W   = 7;
    localparam int MODE_W  = 2;
    localparam int SLOPE_W = 8;
    localparam int OP_W    = 2;
    localparam int VAL_W   = 16;
    localparam int FRAC_W  = 8;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int ACC_W   = 40;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WEIGHT = 2'd0;
    localparam logic [OP_W-1:0] OP_BIAS   = 2'd1;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_MODE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAKY_SLOPE   = 2'd3;

    // Activation codes; anything else passes the logit through
    localparam logic [MODE_W-1:0] ACT_RELU  = 2'd1;
    localparam logic [MODE_W-1:0] ACT_LEAKY = 2'd2;

    // Reset values of the registers
    localparam logic [LEN_W-1:0]   RST_INPUT_LENGTH  = 7'd64;
    localparam logic [LEN_W-1:0]   RST_OUTPUT_LENGTH = 7'd64;
    localparam logic [MODE_W-1:0]  RST_ACT_MODE      = 2'd0;
    localparam logic [SLOPE_W-1:0] RST_LEAKY_SLOPE   = 8'd3;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Control of the multiply-accumulate pipeline
    typedef struct packed {
        logic             valid;
        logic             first;
        logic [OUT_W-1:0] col;
    } t_mac_ctl;

    // Control of the result stage
    typedef struct packed {
        logic             load_logit;
        logic             load_out;
        logic [OUT_W-1:0] col;
        logic             last;
    } t_act_ctl;

    // Clamp a length register to 1..lim
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                   input logic [LEN_W-1:0] lim);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dlf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dlf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/dlf_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dlf_mac (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire dlf_pkg::t_mac_ctl                 i_ctl,
    input  wire logic signed [dlf_pkg::VAL_W-1:0]  i_value,
    input  wire logic signed [dlf_pkg::VAL_W-1:0]  i_weight,
    input  wire logic signed [dlf_pkg::VAL_W-1:0]  i_bias,
    input  wire logic signed [dlf_pkg::ACC_W-1:0]  i_acc,
    output logic                                   o_acc_we,
    output logic             [dlf_pkg::OUT_W-1:0]  o_acc_waddr,
    output logic signed      [dlf_pkg::ACC_W-1:0]  o_acc_wdata
);
    import dlf_pkg::*;

    t_mac_ctl                  r_ctl1;
    t_mac_ctl                  r_ctl2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_base;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [ACC_W-1:0]   n_base;
    logic signed [ACC_W:0]     w_sum;

    // Stage 1: RAM data is here; multiply and pick the starting value
    always_comb begin
        n_prod = i_value * i_weight;
        if (r_ctl1.first) begin
            n_base = {{(ACC_W-VAL_W-FRAC_W){i_bias[VAL_W-1]}}, i_bias, {FRAC_W{1'b0}}};
        end else begin
            n_base = i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
        r_prod <= n_prod;
        r_base <= n_base;
    end

    // Stage 2: saturating add, write back
    assign w_sum = (ACC_W+1)'(r_base) + (ACC_W+1)'(r_prod);

    always_comb begin
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            o_acc_wdata = w_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            o_acc_wdata = w_sum[ACC_W-1:0];
        end
    end

    assign o_acc_we    = r_ctl2.valid;
    assign o_acc_waddr = r_ctl2.col;

endmodule

`default_nettype wire

// ===== rtl/dlf_act.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dlf_act (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire dlf_pkg::t_act_ctl                  i_ctl,
    input  wire logic signed [dlf_pkg::ACC_W-1:0]   i_acc,
    input  wire logic        [dlf_pkg::MODE_W-1:0]  i_mode,
    input  wire logic        [dlf_pkg::SLOPE_W-1:0] i_slope,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output logic             [dlf_pkg::OUT_W-1:0]   o_neuron_index,
    output logic signed      [dlf_pkg::VAL_W-1:0]   o_logit_value,
    output logic signed      [dlf_pkg::VAL_W-1:0]   o_activated_value,
    output logic                                    o_last
);
    import dlf_pkg::*;

    localparam int SH_W = ACC_W - FRAC_W;
    localparam int LK_W = VAL_W + SLOPE_W + 1;

    logic signed [VAL_W-1:0] r_logit;
    logic signed [VAL_W-1:0] n_logit;
    logic signed [SH_W-1:0]  w_shift;
    logic signed [LK_W-1:0]  w_leaky;
    logic signed [VAL_W-1:0] n_act;

    // Floor shift, then clip to Q7.8
    assign w_shift = i_acc[ACC_W-1:FRAC_W];

    always_comb begin
        if (w_shift > SH_W'(VAL_MAX)) begin
            n_logit = VAL_MAX;
        end else if (w_shift < SH_W'(VAL_MIN)) begin
            n_logit = VAL_MIN;
        end else begin
            n_logit = w_shift[VAL_W-1:0];
        end
    end

    assign w_leaky = LK_W'(r_logit) * $signed({1'b0, i_slope});

    always_comb begin
        n_act = r_logit;
        if (r_logit[VAL_W-1]) begin
            unique case (i_mode)
                ACT_RELU:  n_act = '0;
                ACT_LEAKY: n_act = w_leaky[VAL_W+FRAC_W-1:FRAC_W];
                default:   n_act = r_logit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
        if (i_ctl.load_logit) begin
            r_logit <= n_logit;
        end
        if (i_ctl.load_out) begin
            o_neuron_index    <= i_ctl.col;
            o_logit_value     <= r_logit;
            o_activated_value <= n_act;
            o_last            <= i_ctl.last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dense_layer_forward_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+---------------------------------------
// request   | in        | i_in_valid / o_in_ready     | operation, row_index, column_index, value
// result    | out       | o_out_valid / i_out_ready   | neuron_index, logit_value,
//           |           |                             | activated_value, last
// config    | in        | i_cfg_we (no wait)          | i_cfg_idx, i_cfg_wdata
//
// A weight or bias write lands in its RAM at accept. For a sample element, one shared
// multiply-accumulate walks the 64 output accumulators, one per cycle, then drains its
// pipeline into the accumulator RAM.
// The final element of a sample is followed by output_length results (clamped to 1..64);
// each goes through accumulator read, logit clip, activation and handoff, and waits under stall.
// o_in_ready is high only while the sequencer is idle; a result waits in its output
// register until taken. Reset (synchronous, active low) clears control state and the
// element count; weight, bias and accumulator RAMs hold no reset.

module dense_layer_forward_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic        [dlf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic        [dlf_pkg::CFG_W-1:0]    i_cfg_wdata,
    // requests
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic        [dlf_pkg::OP_W-1:0]     i_operation,
    input  wire logic        [dlf_pkg::IN_W-1:0]     i_row_index,
    input  wire logic        [dlf_pkg::OUT_W-1:0]    i_column_index,
    input  wire logic signed [dlf_pkg::VAL_W-1:0]    i_value,
    // results
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic             [dlf_pkg::OUT_W-1:0]    o_neuron_index,
    output logic signed      [dlf_pkg::VAL_W-1:0]    o_logit_value,
    output logic signed      [dlf_pkg::VAL_W-1:0]    o_activated_value,
    output logic                                     o_last
);
    import dlf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN1,
        S_DRAIN2,
        S_RD,
        S_LOGIT,
        S_ACT,
        S_SEND
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [LEN_W-1:0]   r_input_length;
    logic [LEN_W-1:0]   r_output_length;
    logic [MODE_W-1:0]  r_act_mode;
    logic [SLOPE_W-1:0] r_leaky_slope;

    // Sequencer state
    logic [IN_W-1:0]         r_count, n_count;
    logic [OUT_W-1:0]        r_j, n_j;
    logic signed [VAL_W-1:0] r_value, n_value;
    logic                    r_end, n_end;

    logic             w_in_accept;
    logic [LEN_W-1:0] w_nin;
    logic [LEN_W-1:0] w_nout;
    logic             w_last_col;

    t_mac_ctl w_mac_ctl;
    t_act_ctl w_act_ctl;

    logic signed [VAL_W-1:0] w_weight;
    logic signed [VAL_W-1:0] w_bias;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_acc_we;
    logic [OUT_W-1:0]        w_acc_waddr;
    logic signed [ACC_W-1:0] w_acc_wdata;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_nin       = clamp_len(r_input_length, LEN_W'(MAX_INPUTS));
    assign w_nout      = clamp_len(r_output_length, LEN_W'(MAX_OUTPUTS));
    assign w_last_col  = ((LEN_W'(r_j) + LEN_W'(1)) == w_nout);

    // Weight store: row is the element number, column the output neuron
    dlf_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_INPUTS * MAX_OUTPUTS)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_accept && (i_operation == OP_WEIGHT)),
        .i_waddr ({i_row_index, i_column_index}),
        .i_wdata (i_value),
        .i_raddr ({r_count, r_j}),
        .o_rdata (w_weight)
    );

    dlf_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_OUTPUTS)
    ) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_accept && (i_operation == OP_BIAS)),
        .i_waddr (i_column_index),
        .i_wdata (i_value),
        .i_raddr (r_j),
        .o_rdata (w_bias)
    );

    // Accumulators: read by the MAC walk and by the result walk, both at r_j
    dlf_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_OUTPUTS)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc_we),
        .i_waddr (w_acc_waddr),
        .i_wdata (w_acc_wdata),
        .i_raddr (r_j),
        .o_rdata (w_acc)
    );

    dlf_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_mac_ctl),
        .i_value     (r_value),
        .i_weight    (w_weight),
        .i_bias      (w_bias),
        .i_acc       (w_acc),
        .o_acc_we    (w_acc_we),
        .o_acc_waddr (w_acc_waddr),
        .o_acc_wdata (w_acc_wdata)
    );

    dlf_act u_act (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_act_ctl),
        .i_acc             (w_acc),
        .i_mode            (r_act_mode),
        .i_slope           (r_leaky_slope),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_neuron_index    (o_neuron_index),
        .o_logit_value     (o_logit_value),
        .o_activated_value (o_activated_value),
        .o_last            (o_last)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_j     = r_j;
        n_value = r_value;
        n_end   = r_end;

        w_mac_ctl       = '0;
        w_mac_ctl.col   = r_j;
        w_mac_ctl.first = (r_count == '0);

        w_act_ctl      = '0;
        w_act_ctl.col  = r_j;
        w_act_ctl.last = w_last_col;

        unique case (r_state)
            S_IDLE: begin
                // Writes land in the RAMs at accept; only a sample element starts work
                if (w_in_accept && (i_operation == OP_SAMPLE)) begin
                    n_value = i_value;
                    n_end   = ((LEN_W'(r_count) + LEN_W'(1)) >= w_nin);
                    n_j     = '0;
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                // Issue one column per cycle into the MAC pipeline
                w_mac_ctl.valid = 1'b1;
                n_j = r_j + OUT_W'(1);
                if (r_j == OUT_W'(MAX_OUTPUTS - 1)) begin
                    n_state = S_DRAIN1;
                end
            end
            S_DRAIN1: begin
                n_state = S_DRAIN2;
            end
            S_DRAIN2: begin
                // Last write-back is issued in this state; close the element
                n_j = '0;
                if (r_end) begin
                    n_count = '0;
                    n_state = S_RD;
                end else begin
                    n_count = r_count + IN_W'(1);
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_LOGIT;
            end
            S_LOGIT: begin
                w_act_ctl.load_logit = 1'b1;
                n_state = S_ACT;
            end
            S_ACT: begin
                w_act_ctl.load_out = 1'b1;
                n_state = S_SEND;
            end
            S_SEND: begin
                // Hold until the result is taken, then advance
                if (o_out_valid && i_out_ready) begin
                    if (w_last_col) begin
                        n_j     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + OUT_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_count         <= '0;
            r_j             <= '0;
            r_end           <= 1'b0;
            r_input_length  <= RST_INPUT_LENGTH;
            r_output_length <= RST_OUTPUT_LENGTH;
            r_act_mode      <= RST_ACT_MODE;
            r_leaky_slope   <= RST_LEAKY_SLOPE;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_j     <= n_j;
            r_end   <= n_end;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_INPUT_LENGTH:  r_input_length  <= i_cfg_wdata[LEN_W-1:0];
                    CFG_OUTPUT_LENGTH: r_output_length <= i_cfg_wdata[LEN_W-1:0];
                    CFG_ACT_MODE:      r_act_mode      <= i_cfg_wdata[MODE_W-1:0];
                    CFG_LEAKY_SLOPE:   r_leaky_slope   <= i_cfg_wdata[SLOPE_W-1:0];
                    default:           r_act_mode      <= r_act_mode;
                endcase
            end
        end
        r_value <= n_value;
    end

endmodule

`default_nettype wire
